// ===== hdl/oaht_pkg.sv =====
// Shared codes, register map and control types for the open-addressing hash table.
package oaht_pkg;

   localparam int CFG_SIZE_BITS  = 11;
   localparam int CFG_MOD_BITS   = 10;
   localparam int CFG_LIMIT_BITS = 6;

   localparam logic [CFG_SIZE_BITS-1:0]  RST_SIZE  = 11'd1021;
   localparam logic [CFG_MOD_BITS-1:0]   RST_MOD   = 10'd773;
   localparam logic [CFG_LIMIT_BITS-1:0] RST_LIMIT = 6'd25;
   localparam logic                      RST_PMODE = 1'b0;

   localparam logic [1:0] REG_SIZE  = 2'd0;
   localparam logic [1:0] REG_MOD   = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;
   localparam logic [1:0] REG_PMODE = 2'd3;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic PMODE_QUAD   = 1'b0;
   localparam logic PMODE_DOUBLE = 1'b1;

   localparam logic [2:0] STS_INSERTED = 3'd0;
   localparam logic [2:0] STS_FOUND    = 3'd1;
   localparam logic [2:0] STS_MISSING  = 3'd2;
   localparam logic [2:0] STS_FULL     = 3'd3;
   localparam logic [2:0] STS_CLEARED  = 3'd4;

   typedef struct packed {
      logic       sweep_wr;
      logic       load;
      logic       rem_step;
      logic       step_init;
      logic       step_step;
      logic       probe_init;
      logic       rd;
      logic       adv;
      logic       wr;
      logic       res_load;
      logic [2:0] res_status;
      logic       res_hit;
      logic       res_zero;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic sweep_last;
      logic entry_valid;
      logic key_match;
      logic probe_last;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/oaht_dp.sv =====
// Datapath: remainder units, probe address generator, slot memory and result register.
module oaht_dp #(
   parameter int TABLE_DEPTH     = 1024,
   parameter int KEY_BITS        = 24,
   parameter int MAX_PROBE_LIMIT = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  oaht_pkg::cmd_type                      cmd,
   output oaht_pkg::sts_type                      sts,
   input  logic [KEY_BITS-1:0]                    req_key,
   input  logic [oaht_pkg::CFG_SIZE_BITS-1:0]     cfg_size,
   input  logic [oaht_pkg::CFG_MOD_BITS-1:0]      cfg_mod,
   input  logic [oaht_pkg::CFG_LIMIT_BITS-1:0]    cfg_limit,
   input  logic                                   cfg_pmode,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [2:0]                             rsp_status,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rsp_slot,
   output logic [$clog2(MAX_PROBE_LIMIT+1)-1:0]   rsp_probes_used
);
   import oaht_pkg::*;

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int MW      = AW + 1;
   localparam int PW      = $clog2(MAX_PROBE_LIMIT + 1);
   localparam int RW      = CFG_MOD_BITS;
   localparam int CNT_MAX = (KEY_BITS > RW) ? KEY_BITS : RW;
   localparam int CW      = $clog2(CNT_MAX);
   localparam int EW      = KEY_BITS + 1;

   logic [MW-1:0] m_eff;
   logic [RW-1:0] r_eff;
   logic [PW-1:0] lim_eff;

   logic [KEY_BITS-1:0] key_ff, ksh_ff;
   logic [MW-1:0]       remm_ff, remm_in;
   logic [RW-1:0]       remr_ff, remr_in;
   logic [CW-1:0]       cnt_ff;
   logic [RW-1:0]       step_ff;
   logic [MW-1:0]       stepm_ff, stepm_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [MW-1:0]       d_ff, d_in;
   logic [PW-1:0]       k_ff, k_next;
   logic [AW-1:0]       sweep_ff;
   logic [EW-1:0]       rd_ff;
   logic [EW-1:0]       mem [TABLE_DEPTH];

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [AW-1:0]       rsp_slot_ff;
   logic [PW-1:0]       rsp_probes_ff;

   logic [MW:0] remm_sh, stepm_sh, psum, dsum;
   logic [RW:0] remr_sh;
   logic [MW-1:0] incr;

   always_comb begin
      if (cfg_size < 11'd2) begin
         m_eff = MW'(2);
      end else if (32'(cfg_size) > 32'(TABLE_DEPTH)) begin
         m_eff = MW'(TABLE_DEPTH);
      end else begin
         m_eff = MW'(cfg_size);
      end
      r_eff = (cfg_mod == '0) ? RW'(1) : cfg_mod;
      if (cfg_limit == '0) begin
         lim_eff = PW'(1);
      end else if (32'(cfg_limit) > 32'(MAX_PROBE_LIMIT)) begin
         lim_eff = PW'(MAX_PROBE_LIMIT);
      end else begin
         lim_eff = PW'(cfg_limit);
      end
   end

   always_comb begin
      remm_sh  = {remm_ff, ksh_ff[KEY_BITS-1]};
      remm_in  = (remm_sh >= {1'b0, m_eff}) ? MW'(remm_sh - {1'b0, m_eff}) : MW'(remm_sh);
      remr_sh  = {remr_ff, ksh_ff[KEY_BITS-1]};
      remr_in  = (remr_sh >= {1'b0, r_eff}) ? RW'(remr_sh - {1'b0, r_eff}) : RW'(remr_sh);
      stepm_sh = {stepm_ff, step_ff[RW-1]};
      stepm_in = (stepm_sh >= {1'b0, m_eff}) ? MW'(stepm_sh - {1'b0, m_eff}) : MW'(stepm_sh);
      incr     = (cfg_pmode == PMODE_DOUBLE) ? stepm_ff : d_ff;
      psum     = {2'b00, pos_ff} + {1'b0, incr};
      pos_in   = (psum >= {1'b0, m_eff}) ? AW'(psum - {1'b0, m_eff}) : AW'(psum);
      dsum     = {1'b0, d_ff} + (MW + 1)'(2);
      d_in     = (dsum >= {1'b0, m_eff}) ? MW'(dsum - {1'b0, m_eff}) : MW'(dsum);
      k_next   = k_ff + PW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_key;
         ksh_ff  <= req_key;
         remm_ff <= '0;
         remr_ff <= '0;
         cnt_ff  <= CW'(KEY_BITS - 1);
      end else if (cmd.rem_step) begin
         ksh_ff  <= {ksh_ff[KEY_BITS-2:0], 1'b0};
         remm_ff <= remm_in;
         remr_ff <= remr_in;
         cnt_ff  <= cnt_ff - CW'(1);
      end else if (cmd.step_init) begin
         step_ff  <= r_eff - remr_ff;
         stepm_ff <= '0;
         cnt_ff   <= CW'(RW - 1);
      end else if (cmd.step_step) begin
         step_ff  <= {step_ff[RW-2:0], 1'b0};
         stepm_ff <= stepm_in;
         cnt_ff   <= cnt_ff - CW'(1);
      end
      if (cmd.probe_init) begin
         pos_ff <= remm_ff[AW-1:0];
         d_ff   <= MW'(1);
         k_ff   <= '0;
      end else if (cmd.adv) begin
         pos_ff <= pos_in;
         d_ff   <= d_in;
         k_ff   <= k_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_wr) begin
         sweep_ff <= sts.sweep_last ? '0 : sweep_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_wr) begin
         mem[sweep_ff] <= '0;
      end else if (cmd.wr) begin
         mem[pos_ff] <= {1'b1, key_ff};
      end
      if (cmd.rd) begin
         rd_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_status_ff <= cmd.res_status;
         rsp_slot_ff   <= cmd.res_hit ? pos_ff : '0;
         rsp_probes_ff <= cmd.res_zero ? '0 : k_next;
      end
   end

   assign sts.cnt_zero    = (cnt_ff == '0);
   assign sts.sweep_last  = (sweep_ff == AW'(TABLE_DEPTH - 1));
   assign sts.entry_valid = rd_ff[EW-1];
   assign sts.key_match   = (rd_ff[KEY_BITS-1:0] == key_ff);
   assign sts.probe_last  = (k_next == lim_eff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_probes_used = rsp_probes_ff;

endmodule

// ===== hdl/oaht_ctrl.sv =====
// Controller state machine: sequences hashing, probing, clearing and result handoff.
module oaht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  oaht_pkg::sts_type sts,
   output oaht_pkg::cmd_type cmd
);
   import oaht_pkg::*;

   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SINIT = 4'd3;
   localparam logic [3:0] S_SDIV  = 4'd4;
   localparam logic [3:0] S_PINIT = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_CHK   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       ins_ff, ins_in;
   logic       clr_ff, clr_in;
   logic [2:0] res_ff, res_in;
   logic       hit_ff, hit_in;
   logic       zero_ff, zero_in;

   always_comb begin
      state_in  = state_ff;
      ins_in    = ins_ff;
      clr_in    = clr_ff;
      res_in    = res_ff;
      hit_in    = hit_ff;
      zero_in   = zero_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               if (clr_ff) begin
                  clr_in   = 1'b0;
                  res_in   = STS_CLEARED;
                  hit_in   = 1'b0;
                  zero_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               ins_in   = (req_mode == OP_INSERT);
               if (req_mode == OP_CLEAR) begin
                  clr_in   = 1'b1;
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.rem_step = 1'b1;
            if (sts.cnt_zero) begin
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            cmd.step_init = 1'b1;
            state_in      = S_SDIV;
         end
         S_SDIV: begin
            cmd.step_step = 1'b1;
            if (sts.cnt_zero) begin
               state_in = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.probe_init = 1'b1;
            state_in       = S_RD;
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            zero_in  = 1'b0;
            hit_in   = 1'b0;
            state_in = S_DONE;
            if (ins_ff) begin
               if (!sts.entry_valid) begin
                  cmd.wr = 1'b1;
                  res_in = STS_INSERTED;
                  hit_in = 1'b1;
               end else if (sts.probe_last) begin
                  res_in = STS_FULL;
               end else begin
                  cmd.adv  = 1'b1;
                  state_in = S_RD;
               end
            end else begin
               if (!sts.entry_valid) begin
                  res_in = STS_MISSING;
               end else if (sts.key_match) begin
                  res_in = STS_FOUND;
                  hit_in = 1'b1;
               end else if (sts.probe_last) begin
                  res_in = STS_MISSING;
               end else begin
                  cmd.adv  = 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.res_load   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.res_status = res_ff;
      cmd.res_hit    = hit_ff;
      cmd.res_zero   = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         clr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff  <= ins_in;
      res_ff  <= res_in;
      hit_ff  <= hit_in;
      zero_ff <= zero_in;
   end

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// Top level: register port, controller and datapath of the open-addressing hash table.
//
// Request channel (req_valid/req_ready, req_mode, req_key) takes one insert, search
// or clear per beat; the response channel (rsp_valid/rsp_ready) returns one beat
// per request with status, slot and probes used.
// Insert and search: the key is reduced mod size and mod the second modulus (one bit
// per cycle), then the step is reduced mod size; probing then starts, each probe being
// a memory read followed by a check/write, and the result is loaded into the output
// register once the receiver has taken the previous response.
// Clear: one slot per cycle over all TABLE_DEPTH slots, then the response.
// Reset starts the same clearing pass; no request is taken until it ends, while
// register writes are taken at any time.
// Only one request is in flight; the next is taken once the result is in the
// output register, even while the receiver stalls that beat.
// Registers: 0 table size, 1 second modulus, 2 probe limit, 3 probe mode, at 4*i.
module open_addressing_hash_table #(
   parameter int TABLE_DEPTH     = 1024,
   parameter int KEY_BITS        = 24,
   parameter int MAX_PROBE_LIMIT = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [KEY_BITS-1:0]                  req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [$clog2(TABLE_DEPTH)-1:0]       rsp_slot,
   output logic [$clog2(MAX_PROBE_LIMIT+1)-1:0] rsp_probes_used,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [3:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import oaht_pkg::*;

   localparam int SLOT_BITS  = $clog2(TABLE_DEPTH);
   localparam int PROBE_BITS = $clog2(MAX_PROBE_LIMIT + 1);

   logic [CFG_SIZE_BITS-1:0]  size_ff;
   logic [CFG_MOD_BITS-1:0]   mod_ff;
   logic [CFG_LIMIT_BITS-1:0] limit_ff;
   logic                      pmode_ff;
   logic                      wr_en;
   logic [1:0]                reg_idx;
   cmd_type                   cmd;
   sts_type                   sts;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= RST_SIZE;
         mod_ff   <= RST_MOD;
         limit_ff <= RST_LIMIT;
         pmode_ff <= RST_PMODE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SIZE:  size_ff  <= csr_pwdata[CFG_SIZE_BITS-1:0];
            REG_MOD:   mod_ff   <= csr_pwdata[CFG_MOD_BITS-1:0];
            REG_LIMIT: limit_ff <= csr_pwdata[CFG_LIMIT_BITS-1:0];
            REG_PMODE: pmode_ff <= csr_pwdata[0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SIZE:  csr_prdata = 32'(size_ff);
         REG_MOD:   csr_prdata = 32'(mod_ff);
         REG_LIMIT: csr_prdata = 32'(limit_ff);
         REG_PMODE: csr_prdata = 32'(pmode_ff);
         default:   csr_prdata = '0;
      endcase
   end

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_dp #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .KEY_BITS        (KEY_BITS),
      .MAX_PROBE_LIMIT (MAX_PROBE_LIMIT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_key         (req_key),
      .cfg_size        (size_ff),
      .cfg_mod         (mod_ff),
      .cfg_limit       (limit_ff),
      .cfg_pmode       (pmode_ff),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_probes_used (rsp_probes_used)
   );

endmodule

// ===== hdl/oaht_check.sv =====
// Port-level checker for the hash table, bound to the top level.
module oaht_check #(
   parameter int SLOT_BITS  = 10,
   parameter int PROBE_BITS = 6
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            rsp_status,
   input logic [SLOT_BITS-1:0]  rsp_slot,
   input logic [PROBE_BITS-1:0] rsp_probes_used
);
   import oaht_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_CLEARED)
      else $error("undefined status");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_FOUND && rsp_status != STS_INSERTED |-> rsp_slot == '0)
      else $error("slot set without hit");

   a_clear_probes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_CLEARED |-> rsp_probes_used == '0)
      else $error("clear reported probes");

   a_hit_probes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_FOUND || rsp_status == STS_INSERTED)
         |-> rsp_probes_used != '0)
      else $error("hit with no probe");

endmodule

bind open_addressing_hash_table oaht_check #(
   .SLOT_BITS  (SLOT_BITS),
   .PROBE_BITS (PROBE_BITS)
) u_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_probes_used (rsp_probes_used)
);
